// ===== hdl/msp_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// msp_pkg
// Shared types, constants and controller/datapath command codes for the
// masonry span placer.
// ---------------------------------------------------------------------------
package msp_pkg;

    localparam int MAX_COLUMNS_DEF = 16;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam int HEIGHT_W = 24;
    localparam int PIX_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_COLUMN_WIDTH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLUMNS      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GROUP_MARGIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SCENE_HEIGHT = 3'd4;

    // register reset values
    localparam logic [11:0] COLUMN_WIDTH_RST     = 12'd200;
    localparam logic [4:0]  NUM_COLUMNS_RST      = 5'd4;
    localparam logic [15:0] LEVEL_THRESHOLD_RST  = 16'd50;
    localparam logic [15:0] GROUP_MARGIN_RST     = 16'd25;
    localparam logic [15:0] MIN_SCENE_HEIGHT_RST = 16'd0;

    // command codes
    localparam logic CMD_PLACE  = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    // result kinds
    localparam logic KIND_PLACE = 1'b0;
    localparam logic KIND_SIZE  = 1'b1;

    typedef struct packed {
        logic        cmd;
        logic [15:0] item_id;
        logic [4:0]  span;
        logic [15:0] item_height;
        logic        group_change;
    } in_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] item_id_res;
        logic [15:0] x_pos;
        logic [23:0] y_pos;
        logic        last;
    } out_t;

    // pending queue entry
    typedef struct packed {
        logic [15:0] id;
        logic [4:0]  span;
        logic [15:0] height;
    } qent_t;

    // datapath operations issued by the controller
    typedef enum logic [4:0] {
        OP_NONE,
        OP_LATCH,
        OP_LOAD_Q,
        OP_LOAD_ITEM,
        OP_LOW_INIT,
        OP_LOW_STEP,
        OP_WIN_SETUP,
        OP_WIN_BEGIN,
        OP_WIN_STEP,
        OP_WIN_NEXT,
        OP_SEL_LEVEL,
        OP_LW_INIT,
        OP_LW_BEGIN,
        OP_LW_STEP,
        OP_LW_EVAL,
        OP_SEL_LOW,
        OP_EMIT,
        OP_RAISE,
        OP_DEQ,
        OP_ENQ,
        OP_TALL_INIT,
        OP_TALL_STEP,
        OP_LIFT_INIT,
        OP_LIFT,
        OP_EMIT_SIZE,
        OP_CLEAR,
        OP_FLUSH
    } op_t;

    typedef struct packed {
        op_t op;
    } ctl_t;

    typedef struct packed {
        logic qempty;
        logic qfull;
        logic finish;
        logic grp;
        logic last_col;
        logic win_end;
        logic raise_end;
        logic win_none;
        logic win_level;
        logic lw_done;
    } sts_t;

endpackage
`default_nettype wire

// ===== hdl/masonry_span_placer.sv =====
`default_nettype none
// Column heights come from a RAM with a registered read. A request runs, as it needs them,
// a level try over the windows around the lowest column, a forced placement on the window
// with the lowest top, emit and raise, a group lift and the size report.
// Results wait in a one-deep buffer until the next is made; the last one comes out in
// the first cycle with busy low. Throughput: one request at a time, taken when busy is low.
// Reset: clears the columns and the queue and resets the registers; the receiver cannot stall.
// ---------------------------------------------------------------------------
// masonry_span_placer
// Top level: skyline masonry placement of items over a row of columns, with
// a pending queue, group breaks and a finish command reporting the size.
// ---------------------------------------------------------------------------
module masonry_span_placer
    import msp_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire in_t                  request,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    output logic                      result_valid,
    output out_t                      result
);

    ctl_t ctl;
    sts_t sts;

    // configuration is always taken
    assign cfg_ready = 1'b1;

    // sequencer
    msp_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .ctl   (ctl),
        .sts   (sts)
    );

    // datapath
    msp_dp #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctl          (ctl),
        .sts          (sts),
        .request      (request),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
`default_nettype wire

// ===== hdl/msp_ram.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// msp_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module msp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== hdl/msp_ctrl.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// msp_ctrl
// Sequencer for the placer: drains the pending queue, handles group breaks,
// places the request or reports the size, and issues one datapath operation per cycle.
// ---------------------------------------------------------------------------
module msp_ctrl
    import msp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output ctl_t      ctl,
    input  wire sts_t sts
);

    typedef enum logic [4:0] {
        S_IDLE, S_DL, S_DL_LOAD, S_AFTER_DL, S_DF, S_DF_LOAD, S_ITEM, S_ITEM_FAIL,
        S_LV_LOWI, S_LV_LOWA, S_LV_LOWD, S_LV_SETUP, S_LV_WCHK, S_LV_WA, S_LV_WD,
        S_LV_WEVAL, S_LW_INIT, S_LW_CHK, S_LW_A, S_LW_D, S_LW_EVAL, S_EMIT,
        S_RAISE, S_DEQ, S_TALL_I, S_TALL_A, S_TALL_D, S_LIFT_I, S_LIFT, S_SIZE,
        S_CLEAR, S_DONE
    } state_t;

    // who called the placement routine
    typedef enum logic [1:0] {
        P_DL, P_DF, P_ITEM, P_FORCE_ITEM
    } proc_t;

    state_t state_reg, state_next;
    proc_t  proc_reg, proc_next;
    op_t    op;

    // next state and operation decode
    always_comb
    begin
        state_next = state_reg;
        proc_next  = proc_reg;
        op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op         = OP_LATCH;
                    state_next = S_DL;
                end
            end
            S_DL:       state_next = sts.qempty ? S_AFTER_DL : S_DL_LOAD;
            S_DL_LOAD:
            begin
                op         = OP_LOAD_Q;
                proc_next  = P_DL;
                state_next = S_LV_LOWI;
            end
            S_AFTER_DL: state_next = (sts.finish || sts.grp) ? S_DF : S_ITEM;
            S_DF:       state_next = sts.qempty ? S_TALL_I : S_DF_LOAD;
            S_DF_LOAD:
            begin
                op         = OP_LOAD_Q;
                proc_next  = P_DF;
                state_next = S_LW_INIT;
            end
            S_ITEM:
            begin
                op         = OP_LOAD_ITEM;
                proc_next  = P_ITEM;
                state_next = S_LV_LOWI;
            end
            S_ITEM_FAIL:
            begin
                if (!sts.qfull)
                begin
                    op         = OP_ENQ;
                    state_next = S_DONE;
                end
                else
                begin
                    proc_next  = P_FORCE_ITEM;
                    state_next = S_LW_INIT;
                end
            end
            // level placement: lowest column, then candidate windows
            S_LV_LOWI:
            begin
                op         = OP_LOW_INIT;
                state_next = S_LV_LOWA;
            end
            S_LV_LOWA:  state_next = S_LV_LOWD;
            S_LV_LOWD:
            begin
                op         = OP_LOW_STEP;
                state_next = sts.last_col ? S_LV_SETUP : S_LV_LOWA;
            end
            S_LV_SETUP:
            begin
                op         = OP_WIN_SETUP;
                state_next = S_LV_WCHK;
            end
            S_LV_WCHK:
            begin
                if (sts.win_none)
                begin
                    state_next = (proc_reg == P_DL) ? S_AFTER_DL : S_ITEM_FAIL;
                end
                else
                begin
                    op         = OP_WIN_BEGIN;
                    state_next = S_LV_WA;
                end
            end
            S_LV_WA:    state_next = S_LV_WD;
            S_LV_WD:
            begin
                op         = OP_WIN_STEP;
                state_next = sts.win_end ? S_LV_WEVAL : S_LV_WA;
            end
            S_LV_WEVAL:
            begin
                if (sts.win_level)
                begin
                    op         = OP_SEL_LEVEL;
                    state_next = S_EMIT;
                end
                else
                begin
                    op         = OP_WIN_NEXT;
                    state_next = S_LV_WCHK;
                end
            end
            // forced placement on the lowest window
            S_LW_INIT:
            begin
                op         = OP_LW_INIT;
                state_next = S_LW_CHK;
            end
            S_LW_CHK:
            begin
                if (sts.lw_done)
                begin
                    op         = OP_SEL_LOW;
                    state_next = S_EMIT;
                end
                else
                begin
                    op         = OP_LW_BEGIN;
                    state_next = S_LW_A;
                end
            end
            S_LW_A:     state_next = S_LW_D;
            S_LW_D:
            begin
                op         = OP_LW_STEP;
                state_next = sts.win_end ? S_LW_EVAL : S_LW_A;
            end
            S_LW_EVAL:
            begin
                op         = OP_LW_EVAL;
                state_next = S_LW_CHK;
            end
            // report placement and raise the window
            S_EMIT:
            begin
                op         = OP_EMIT;
                state_next = S_RAISE;
            end
            S_RAISE:
            begin
                op = OP_RAISE;
                if (sts.raise_end)
                begin
                    state_next = (proc_reg == P_DL || proc_reg == P_DF) ? S_DEQ : S_DONE;
                end
            end
            S_DEQ:
            begin
                op         = OP_DEQ;
                state_next = (proc_reg == P_DL) ? S_DL : S_DF;
            end
            // tallest column, then group lift or size report
            S_TALL_I:
            begin
                op         = OP_TALL_INIT;
                state_next = S_TALL_A;
            end
            S_TALL_A:   state_next = S_TALL_D;
            S_TALL_D:
            begin
                op = OP_TALL_STEP;
                if (sts.last_col)
                begin
                    state_next = sts.finish ? S_SIZE : S_LIFT_I;
                end
                else
                begin
                    state_next = S_TALL_A;
                end
            end
            S_LIFT_I:
            begin
                op         = OP_LIFT_INIT;
                state_next = S_LIFT;
            end
            S_LIFT:
            begin
                op         = OP_LIFT;
                state_next = sts.last_col ? S_ITEM : S_LIFT;
            end
            S_SIZE:
            begin
                op         = OP_EMIT_SIZE;
                state_next = S_CLEAR;
            end
            S_CLEAR:
            begin
                op         = OP_CLEAR;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                op         = OP_FLUSH;
                state_next = S_IDLE;
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            proc_reg  <= P_DL;
        end
        else
        begin
            state_reg <= state_next;
            proc_reg  <= proc_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign ctl.op = op;

endmodule
`default_nettype wire

// ===== hdl/msp_dp.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// msp_dp
// Datapath: column height store, pending queue, scan registers, config
// registers and the one-deep result buffer that marks the last result.
// ---------------------------------------------------------------------------
module msp_dp
    import msp_pkg::*;
#(
    parameter int MAX_COLUMNS = MAX_COLUMNS_DEF,
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ctl_t                 ctl,
    output sts_t                      sts,
    input  wire in_t                  request,
    input  wire logic                 cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_DAT_W-1:0] cfg_data,
    output logic                      result_valid,
    output out_t                      result
);

    localparam int CW  = $clog2(MAX_COLUMNS);
    localparam int CNW = $clog2(MAX_COLUMNS + 1);
    localparam int SW  = CNW + 1;
    localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    // configuration
    logic [11:0] cw_reg;
    logic [4:0]  ncol_reg;
    logic [15:0] thr_reg, margin_reg, minh_reg;

    // working registers
    in_t                 item_reg;
    logic [15:0]         cur_id_reg, cur_h_reg;
    logic [4:0]          cur_span_reg;
    logic [CNW-1:0]      c_reg, i_reg, start_reg, low_reg, right_reg, best_reg;
    logic [CW-1:0]       c_d_reg;
    logic [HEIGHT_W-1:0] lowv_reg, lo_reg, hi_reg, top_reg, besth_reg, tall_reg, lift_reg;
    logic                have_reg;
    logic [QW-1:0]       head_reg;
    logic [QCW-1:0]      count_reg;
    logic [MAX_COLUMNS-1:0] hvalid_reg;
    out_t                buf_reg, out_reg;
    logic                buf_valid_reg, out_valid_reg;

    // memories
    logic [HEIGHT_W-1:0] hram_q, h_wdata, hd;
    logic                h_we;
    qent_t               q_rdata, q_wdata;
    logic [QW-1:0]       q_tail;
    logic [QW:0]         q_sum;

    // derived column values
    logic [7:0]     nc8, span8, s8;
    logic [CNW-1:0] n, s;
    logic [SW-1:0]  low1, left_v, lse, right_v;
    logic [HEIGHT_W:0] raise_sum, lift_sum;
    logic [HEIGHT_W-1:0] raise_val, lift_val, size_h;
    logic [31:0]    px, sx;
    logic [15:0]    x_place, x_size;
    out_t           push_data;
    logic           push;

    // columns in use and clamped span
    always_comb
    begin
        nc8 = {3'b000, ncol_reg};
        if (nc8 < 8'd2)
        begin
            nc8 = 8'd2;
        end
        else if (nc8 > 8'(MAX_COLUMNS))
        begin
            nc8 = 8'(MAX_COLUMNS);
        end
        n = CNW'(nc8);
        span8 = {3'b000, cur_span_reg};
        if (span8 == 8'd0)
        begin
            s8 = 8'd1;
        end
        else if (span8 > nc8)
        begin
            s8 = nc8;
        end
        else
        begin
            s8 = span8;
        end
        s = CNW'(s8);
    end

    // window bounds around the lowest column
    always_comb
    begin
        low1   = SW'(low_reg) + SW'(1);
        left_v = (low1 >= SW'(s)) ? (low1 - SW'(s)) : '0;
        lse    = SW'(low_reg) + SW'(s) - SW'(1);
        right_v = (lse > SW'(n) - SW'(1)) ? (SW'(n) - SW'(1)) : lse;
    end

    // saturating sums and pixel products
    always_comb
    begin
        raise_sum = {1'b0, top_reg} + (HEIGHT_W+1)'(cur_h_reg);
        raise_val = raise_sum[HEIGHT_W] ? '1 : raise_sum[HEIGHT_W-1:0];
        lift_sum  = {1'b0, tall_reg} + (HEIGHT_W+1)'(margin_reg);
        lift_val  = lift_sum[HEIGHT_W] ? '1 : lift_sum[HEIGHT_W-1:0];
        size_h    = (HEIGHT_W'(minh_reg) > tall_reg) ? HEIGHT_W'(minh_reg) : tall_reg;
        px        = 32'(start_reg) * 32'(cw_reg);
        sx        = 32'(n) * 32'(cw_reg);
        x_place   = (px > 32'h0000_FFFF) ? 16'hFFFF : px[15:0];
        x_size    = (sx > 32'h0000_FFFF) ? 16'hFFFF : sx[15:0];
    end

    // result to push into the buffer
    always_comb
    begin
        push = (ctl.op == OP_EMIT) || (ctl.op == OP_EMIT_SIZE);
        push_data.last = 1'b0;
        if (ctl.op == OP_EMIT_SIZE)
        begin
            push_data.kind        = KIND_SIZE;
            push_data.item_id_res = '0;
            push_data.x_pos       = x_size;
            push_data.y_pos       = size_h;
        end
        else
        begin
            push_data.kind        = KIND_PLACE;
            push_data.item_id_res = cur_id_reg;
            push_data.x_pos       = x_place;
            push_data.y_pos       = top_reg;
        end
    end

    // height store
    assign hd      = hvalid_reg[c_d_reg] ? hram_q : '0;
    assign h_we    = (ctl.op == OP_RAISE) || (ctl.op == OP_LIFT);
    assign h_wdata = (ctl.op == OP_RAISE) ? raise_val : lift_reg;

    msp_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (MAX_COLUMNS)
    ) u_heights (
        .clk   (clk),
        .we    (h_we),
        .waddr (c_reg[CW-1:0]),
        .wdata (h_wdata),
        .raddr (c_reg[CW-1:0]),
        .rdata (hram_q)
    );

    // pending queue, read always at the head
    always_comb
    begin
        q_sum  = {1'b0, head_reg} + (QW+1)'(count_reg);
        q_tail = (q_sum >= (QW+1)'(QUEUE_DEPTH)) ? QW'(q_sum - (QW+1)'(QUEUE_DEPTH))
                                                 : QW'(q_sum);
        q_wdata.id     = item_reg.item_id;
        q_wdata.span   = item_reg.span;
        q_wdata.height = item_reg.item_height;
    end

    msp_ram #(
        .WIDTH ($bits(qent_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ctl.op == OP_ENQ),
        .waddr (q_tail),
        .wdata (q_wdata),
        .raddr (head_reg),
        .rdata (q_rdata)
    );

    // status to the controller
    always_comb
    begin
        sts.qempty    = (count_reg == '0);
        sts.qfull     = (count_reg == QCW'(QUEUE_DEPTH));
        sts.finish    = (item_reg.cmd == CMD_FINISH);
        sts.grp       = item_reg.group_change;
        sts.last_col  = (c_reg == n - CNW'(1));
        sts.win_end   = (SW'(c_reg) + SW'(1) == SW'(i_reg) + SW'(s));
        sts.raise_end = (SW'(c_reg) + SW'(1) == SW'(start_reg) + SW'(s));
        sts.win_none  = (SW'(i_reg) + SW'(s) > SW'(right_reg) + SW'(1));
        sts.win_level = ((hi_reg - lo_reg) < HEIGHT_W'(thr_reg));
        sts.lw_done   = (SW'(i_reg) + SW'(s) > SW'(n));
    end

    // datapath registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg        <= COLUMN_WIDTH_RST;
            ncol_reg      <= NUM_COLUMNS_RST;
            thr_reg       <= LEVEL_THRESHOLD_RST;
            margin_reg    <= GROUP_MARGIN_RST;
            minh_reg      <= MIN_SCENE_HEIGHT_RST;
            item_reg      <= '0;
            cur_id_reg    <= '0;
            cur_h_reg     <= '0;
            cur_span_reg  <= '0;
            c_reg         <= '0;
            c_d_reg       <= '0;
            i_reg         <= '0;
            start_reg     <= '0;
            low_reg       <= '0;
            right_reg     <= '0;
            best_reg      <= '0;
            lowv_reg      <= '0;
            lo_reg        <= '0;
            hi_reg        <= '0;
            top_reg       <= '0;
            besth_reg     <= '0;
            tall_reg      <= '0;
            lift_reg      <= '0;
            have_reg      <= 1'b0;
            head_reg      <= '0;
            count_reg     <= '0;
            hvalid_reg    <= '0;
            buf_reg       <= '0;
            out_reg       <= '0;
            buf_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            c_d_reg <= c_reg[CW-1:0];

            // configuration writes
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_COLUMN_WIDTH:     cw_reg     <= cfg_data[11:0];
                    REG_NUM_COLUMNS:      ncol_reg   <= cfg_data[4:0];
                    REG_LEVEL_THRESHOLD:  thr_reg    <= cfg_data;
                    REG_GROUP_MARGIN:     margin_reg <= cfg_data;
                    REG_MIN_SCENE_HEIGHT: minh_reg   <= cfg_data;
                    default:              ;
                endcase
            end

            // written columns become valid
            if (h_we)
            begin
                hvalid_reg[c_reg[CW-1:0]] <= 1'b1;
            end

            // one-deep buffer: the previous result leaves when a new one comes,
            // the held one leaves marked last when the request ends
            if (push)
            begin
                out_valid_reg <= buf_valid_reg;
                out_reg       <= buf_reg;
                buf_reg       <= push_data;
                buf_valid_reg <= 1'b1;
            end
            else if (ctl.op == OP_FLUSH)
            begin
                out_valid_reg <= buf_valid_reg;
                out_reg       <= {buf_reg[$bits(out_t)-1:1], 1'b1};
                buf_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (ctl.op)
                OP_LATCH:     item_reg <= request;
                OP_LOAD_Q:
                begin
                    cur_id_reg   <= q_rdata.id;
                    cur_span_reg <= q_rdata.span;
                    cur_h_reg    <= q_rdata.height;
                end
                OP_LOAD_ITEM:
                begin
                    cur_id_reg   <= item_reg.item_id;
                    cur_span_reg <= item_reg.span;
                    cur_h_reg    <= item_reg.item_height;
                end
                OP_LOW_INIT:  c_reg <= '0;
                OP_LOW_STEP:
                begin
                    if (c_reg == '0 || hd < lowv_reg)
                    begin
                        low_reg  <= c_reg;
                        lowv_reg <= hd;
                    end
                    c_reg <= c_reg + CNW'(1);
                end
                OP_WIN_SETUP:
                begin
                    i_reg     <= CNW'(left_v);
                    right_reg <= CNW'(right_v);
                end
                OP_WIN_BEGIN: c_reg <= i_reg;
                OP_WIN_STEP:
                begin
                    if (c_reg == i_reg)
                    begin
                        lo_reg <= hd;
                        hi_reg <= hd;
                    end
                    else
                    begin
                        if (hd < lo_reg)
                        begin
                            lo_reg <= hd;
                        end
                        if (hd > hi_reg)
                        begin
                            hi_reg <= hd;
                        end
                    end
                    c_reg <= c_reg + CNW'(1);
                end
                OP_WIN_NEXT:  i_reg <= i_reg + CNW'(1);
                OP_SEL_LEVEL:
                begin
                    start_reg <= i_reg;
                    top_reg   <= hi_reg;
                end
                OP_LW_INIT:
                begin
                    i_reg    <= '0;
                    have_reg <= 1'b0;
                end
                OP_LW_BEGIN:
                begin
                    c_reg   <= i_reg;
                    top_reg <= '0;
                end
                OP_LW_STEP:
                begin
                    if (hd > top_reg)
                    begin
                        top_reg <= hd;
                    end
                    c_reg <= c_reg + CNW'(1);
                end
                OP_LW_EVAL:
                begin
                    if (!have_reg || top_reg < besth_reg)
                    begin
                        best_reg  <= i_reg;
                        besth_reg <= top_reg;
                        have_reg  <= 1'b1;
                    end
                    i_reg <= i_reg + CNW'(1);
                end
                OP_SEL_LOW:
                begin
                    start_reg <= best_reg;
                    top_reg   <= besth_reg;
                end
                OP_EMIT:      c_reg <= start_reg;
                OP_RAISE:     c_reg <= c_reg + CNW'(1);
                OP_DEQ:
                begin
                    head_reg  <= (head_reg == QW'(QUEUE_DEPTH - 1)) ? '0
                                                                    : head_reg + QW'(1);
                    count_reg <= count_reg - QCW'(1);
                end
                OP_ENQ:       count_reg <= count_reg + QCW'(1);
                OP_TALL_INIT:
                begin
                    c_reg    <= '0;
                    tall_reg <= '0;
                end
                OP_TALL_STEP:
                begin
                    if (hd > tall_reg)
                    begin
                        tall_reg <= hd;
                    end
                    c_reg <= c_reg + CNW'(1);
                end
                OP_LIFT_INIT:
                begin
                    c_reg    <= '0;
                    lift_reg <= lift_val;
                end
                OP_LIFT:      c_reg <= c_reg + CNW'(1);
                OP_CLEAR:
                begin
                    hvalid_reg <= '0;
                    head_reg   <= '0;
                    count_reg  <= '0;
                end
                default:      ;
            endcase
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule
`default_nettype wire

// ===== verif/masonry_span_placer_tb.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// masonry_span_placer_tb
// Self-checking bench for the span placer: directed and random place/finish
// requests over several register settings, checked against an internal
// skyline layout predictor through a small result scoreboard.
// ---------------------------------------------------------------------------

// layout predictor and expected result store
class layout_board;
    logic [23:0]   col_h [16];
    msp_pkg::qent_t pend [16];
    int unsigned   q_head;
    int unsigned   q_cnt;
    logic [11:0]   col_w;
    logic [4:0]    n_cols;
    logic [15:0]   lvl_thr;
    logic [15:0]   grp_gap;
    logic [15:0]   min_h;
    msp_pkg::out_t pending_results [$];
    int            mismatches;
    msp_pkg::out_t step_out [$];

    function new();
        col_w = msp_pkg::COLUMN_WIDTH_RST;
        n_cols = msp_pkg::NUM_COLUMNS_RST;
        lvl_thr = msp_pkg::LEVEL_THRESHOLD_RST;
        grp_gap = msp_pkg::GROUP_MARGIN_RST;
        min_h = msp_pkg::MIN_SCENE_HEIGHT_RST;
        mismatches = 0;
        wipe();
    endfunction

    function void wipe();
        for (int i = 0; i < 16; i++) col_h[i] = '0;
        q_head = 0;
        q_cnt = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            msp_pkg::REG_COLUMN_WIDTH:     col_w = val[11:0];
            msp_pkg::REG_NUM_COLUMNS:      n_cols = val[4:0];
            msp_pkg::REG_LEVEL_THRESHOLD:  lvl_thr = val;
            msp_pkg::REG_GROUP_MARGIN:     grp_gap = val;
            msp_pkg::REG_MIN_SCENE_HEIGHT: min_h = val;
            default: ;
        endcase
    endfunction

    function int unsigned ncols();
        int unsigned n;
        n = n_cols;
        if (n < 2) n = 2;
        if (n > 16) n = 16;
        return n;
    endfunction

    function int unsigned clamp_span(int unsigned s);
        if (s < 1) s = 1;
        if (s > ncols()) s = ncols();
        return s;
    endfunction

    function logic [23:0] hsat(longint unsigned v);
        return (v > 24'hFFFFFF) ? 24'hFFFFFF : v[23:0];
    endfunction

    function logic [15:0] psat(longint unsigned v);
        return (v > 16'hFFFF) ? 16'hFFFF : v[15:0];
    endfunction

    function void note_result(logic kind, logic [15:0] id, logic [15:0] x, logic [23:0] y);
        msp_pkg::out_t r;
        r.kind = kind;
        r.item_id_res = id;
        r.x_pos = x;
        r.y_pos = y;
        r.last = 1'b0;
        step_out.push_back(r);
    endfunction

    function logic [23:0] max_col();
        logic [23:0] m;
        m = '0;
        for (int c = 0; c < ncols(); c++) if (col_h[c] > m) m = col_h[c];
        return m;
    endfunction

    function void raise_cols(int unsigned st, int unsigned s, logic [23:0] top,
                             logic [15:0] h);
        for (int unsigned c = st; c < st + s; c++) col_h[c] = hsat(top + h);
    endfunction

    // first level window around the lowest column
    function bit try_level(msp_pkg::qent_t e);
        int unsigned n, s, low, left, right;
        logic [23:0] lo, hi;
        n = ncols();
        s = clamp_span(e.span);
        low = 0;
        for (int unsigned c = 1; c < n; c++) if (col_h[c] < col_h[low]) low = c;
        left = (low + 1 >= s) ? low + 1 - s : 0;
        right = (low + s - 1 > n - 1) ? n - 1 : low + s - 1;
        for (int unsigned i = left; i + s <= right + 1; i++)
        begin
            lo = col_h[i];
            hi = col_h[i];
            for (int unsigned c = i + 1; c < i + s; c++)
            begin
                if (col_h[c] < lo) lo = col_h[c];
                if (col_h[c] > hi) hi = col_h[c];
            end
            if (hi - lo < lvl_thr)
            begin
                note_result(msp_pkg::KIND_PLACE, e.id, psat(i * col_w), hi);
                raise_cols(i, s, hi, e.height);
                return 1;
            end
        end
        return 0;
    endfunction

    // forced placement on the window with the lowest top
    function void force_low(msp_pkg::qent_t e);
        int unsigned n, s, best;
        logic [23:0] best_h, top;
        bit have;
        n = ncols();
        s = clamp_span(e.span);
        best = 0;
        best_h = '0;
        have = 0;
        for (int unsigned i = 0; i + s <= n; i++)
        begin
            top = '0;
            for (int unsigned c = i; c < i + s; c++) if (col_h[c] > top) top = col_h[c];
            if (!have || top < best_h)
            begin
                have = 1;
                best_h = top;
                best = i;
            end
        end
        note_result(msp_pkg::KIND_PLACE, e.id, psat(best * col_w), best_h);
        raise_cols(best, s, best_h, e.height);
    endfunction

    function void drain(bit forced);
        while (q_cnt > 0)
        begin
            if (forced) force_low(pend[q_head]);
            else if (!try_level(pend[q_head])) return;
            q_head = (q_head + 1) % 16;
            q_cnt--;
        end
    endfunction

    // predict the results of one accepted request
    function void note_request(msp_pkg::in_t rq);
        msp_pkg::qent_t e;
        logic [23:0] lifted, tot;
        step_out.delete();
        e.id = rq.item_id;
        e.span = rq.span;
        e.height = rq.item_height;
        if (rq.cmd == msp_pkg::CMD_PLACE)
        begin
            drain(0);
            if (rq.group_change)
            begin
                drain(1);
                lifted = hsat(max_col() + grp_gap);
                for (int c = 0; c < ncols(); c++) col_h[c] = lifted;
            end
            if (!try_level(e))
            begin
                if (q_cnt < 16)
                begin
                    pend[(q_head + q_cnt) % 16] = e;
                    q_cnt++;
                end
                else force_low(e);
            end
        end
        else
        begin
            drain(0);
            drain(1);
            tot = max_col();
            if (min_h > tot) tot = min_h;
            note_result(msp_pkg::KIND_SIZE, 16'h0, psat(ncols() * col_w), tot);
            wipe();
        end
        if (step_out.size() > 0) step_out[step_out.size() - 1].last = 1'b1;
        foreach (step_out[i]) pending_results.push_back(step_out[i]);
    endfunction

    function void check_result(msp_pkg::out_t got);
        msp_pkg::out_t exp_r;
        if (pending_results.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
            return;
        end
        exp_r = pending_results.pop_front();
        if (got !== exp_r)
        begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p got %p", exp_r, got);
        end
    endfunction
endclass

module masonry_span_placer_tb;
    import msp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 20000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    in_t  request;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;
    logic result_valid;
    out_t result;

    layout_board board;
    int  idle_cycles;
    bit  timed_out;
    bit  calm;

    masonry_span_placer u_top (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .request(request),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .result_valid(result_valid), .result(result)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // result checking and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid) board.check_result(result);
            if (result_valid || (start && !busy) || (cfg_valid && cfg_ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles > STALL_LIMIT && !timed_out)
            begin
                timed_out = 1;
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        board.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send(in_t rq);
        if (!calm && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 9)) @(posedge clk);
        start <= 1'b1;
        request <= rq;
        @(posedge clk);
        while (busy) @(posedge clk);
        board.note_request(rq);
        start <= 1'b0;
        // let start fall before the next request
        @(posedge clk);
    endtask

    task automatic settle();
        while (board.pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    function automatic in_t make_item(logic [15:0] id, logic [4:0] sp, logic [15:0] h,
                                      logic g);
        in_t r;
        r.cmd = CMD_PLACE;
        r.item_id = id;
        r.span = sp;
        r.item_height = h;
        r.group_change = g;
        return r;
    endfunction

    function automatic in_t finish_item();
        in_t r;
        r = in_t'($urandom());
        r.cmd = CMD_FINISH;
        return r;
    endfunction

    function automatic in_t rand_item();
        in_t r;
        r = make_item(16'($urandom()), 5'($urandom_range(1, 16)),
                      16'($urandom_range(0, 400)), ($urandom_range(0, 15) == 0));
        case ($urandom_range(0, 9))
            0: r.item_height = 16'($urandom());
            1: r.span = 5'($urandom());
            2: r = in_t'($urandom() ^ ($urandom() << 7));
            default: ;
        endcase
        return r;
    endfunction

    // directed cases then random phases over several settings
    initial
    begin
        board = new();
        idle_cycles = 0;
        timed_out = 0;
        calm = 0;
        rst_n = 1'b0;
        start = 1'b0;
        request = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: extremes, spans, group break, finish
        send(make_item(16'hFFFF, 5'd1, 16'hFFFF, 1'b0));
        send(make_item(16'h0000, 5'd0, 16'h0000, 1'b0));
        send(make_item(16'h1234, 5'd31, 16'd10, 1'b0));
        send(make_item(16'h0001, 5'd2, 16'd30, 1'b1));
        send(make_item(16'h0002, 5'd16, 16'd5, 1'b0));
        send(finish_item());
        settle();
        // zero threshold: queue fills then forced placement
        write_reg(REG_LEVEL_THRESHOLD, 16'd0);
        write_reg(REG_NUM_COLUMNS, 5'd16);
        write_reg(REG_COLUMN_WIDTH, 12'd4095);
        for (int i = 0; i < 18; i++)
            send(make_item(16'(i), 5'($urandom_range(1, 16)), 16'($urandom()), 1'b0));
        send(make_item(16'hAAAA, 5'd3, 16'd1, 1'b1));
        send(finish_item());
        settle();

        // random phases
        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: begin
                    write_reg(REG_NUM_COLUMNS, 5'd0);
                    write_reg(REG_COLUMN_WIDTH, 12'd1);
                    write_reg(REG_LEVEL_THRESHOLD, 16'hFFFF);
                    write_reg(REG_GROUP_MARGIN, 16'hFFFF);
                    write_reg(REG_MIN_SCENE_HEIGHT, 16'hFFFF);
                end
                1: begin
                    write_reg(REG_NUM_COLUMNS, 5'd31);
                    write_reg(REG_LEVEL_THRESHOLD, 16'd50);
                    write_reg(REG_GROUP_MARGIN, 16'd0);
                    write_reg(REG_MIN_SCENE_HEIGHT, 16'd0);
                end
                2: begin
                    write_reg(REG_COLUMN_WIDTH, 12'($urandom_range(1, 4095)));
                    write_reg(REG_NUM_COLUMNS, 5'($urandom_range(2, 16)));
                    write_reg(REG_LEVEL_THRESHOLD, 16'($urandom_range(0, 300)));
                    write_reg(REG_GROUP_MARGIN, 16'($urandom()));
                    write_reg(REG_MIN_SCENE_HEIGHT, 16'($urandom()));
                end
                3: begin
                    write_reg(REG_NUM_COLUMNS, 5'd2);
                    write_reg(REG_LEVEL_THRESHOLD, 16'd0);
                end
                default: begin
                    write_reg(REG_COLUMN_WIDTH, 12'd200);
                    write_reg(REG_NUM_COLUMNS, 5'($urandom_range(2, 16)));
                    write_reg(REG_LEVEL_THRESHOLD, 16'($urandom_range(20, 200)));
                    write_reg(REG_GROUP_MARGIN, 16'd25);
                end
            endcase
            calm = (ph == 5);
            for (int i = 0; i < 80; i++)
            begin
                if ($urandom_range(0, 24) == 0) send(finish_item());
                else send(rand_item());
                // in phase 2, let everything drain once mid-phase
                if (i == 40 && ph == 2)
                    while (board.pending_results.size() != 0) @(posedge clk);
            end
            send(finish_item());
            settle();
        end

        if (board.mismatches == 0 && board.pending_results.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
`default_nettype wire

// ===== files.f =====
hdl/msp_pkg.sv
hdl/msp_ram.sv
hdl/msp_ctrl.sv
hdl/msp_dp.sv
hdl/masonry_span_placer.sv
verif/masonry_span_placer_tb.sv
